### src/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg: shared definitions for the button debounce press classifier
// Register indexes, register reset values and the result word layout.
// ----------------------------------------------------------------------------
package bdpc_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;

	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_DEBOUNCE_MS  = 2'd0;
	localparam cfg_idx_t CFG_SHORT_MAX_MS = 2'd1;
	localparam cfg_idx_t CFG_LONG_MS      = 2'd2;

	// Register values after reset.
	localparam cfg_data_t DEBOUNCE_MS_RST  = 16'd15;
	localparam cfg_data_t SHORT_MAX_MS_RST = 16'd1000;
	localparam cfg_data_t LONG_MS_RST      = 16'd3000;

	// Released level of the active-low button.
	localparam logic LEVEL_RELEASED = 1'b1;
	localparam logic LEVEL_PRESSED  = 1'b0;

	// One result word.
	typedef struct packed {
		logic stable;
		logic press;
		logic release_ev;
		logic short_ev;
		logic long_ev;
	} result_t;

endpackage

### src/button_debounce_press_classifier.sv
// The input register holds an accepted input word; its result word is
// registered in the result register once that stage is free or being taken.
// Throughput: one word per cycle while out_stall is low; the input register and
// the result register form a two-stage pipeline, and all state is updated in
// the single pass between them. Reset (arst_n low, asynchronous) empties both
// stages, restores the register defaults and sets both button levels to released.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a sampled active-low button once per millisecond tick and flags
// press, release, short-press and long-press events.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write channel.
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  bdpc_pkg::cfg_idx_t  cfg_index,
	input  bdpc_pkg::cfg_data_t cfg_data,
	// Input channel: one word per millisecond tick.
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              raw_level,
	// Output channel: one result word per tick.
	output logic              out_valid,
	input  logic              out_stall,
	output logic              stable_out,
	output logic              press_event,
	output logic              release_event,
	output logic              short_event,
	output logic              long_event
);
	import bdpc_pkg::*;

	// Compare width covers both the timers and the 16-bit registers.
	localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [CMP_W-1:0]       cmp_t;

	// ------------------------------------------------------------------
	// Configuration registers. The port is always ready; an index beyond
	// the register list is simply dropped.
	// ------------------------------------------------------------------
	cfg_data_t debounce_ms_q;
	cfg_data_t short_max_ms_q;
	cfg_data_t long_ms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q  <= DEBOUNCE_MS_RST;
			short_max_ms_q <= SHORT_MAX_MS_RST;
			long_ms_q      <= LONG_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEBOUNCE_MS:  debounce_ms_q  <= cfg_data;
				CFG_SHORT_MAX_MS: short_max_ms_q <= cfg_data;
				CFG_LONG_MS:      long_ms_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control. Stage 1 holds the sampled input word, stage 2 the
	// result word. A word moves from stage 1 to stage 2 whenever stage 2 is
	// empty or is being taken this cycle, so a waiting result stalls the
	// input only once stage 1 also holds a word.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic raw_s1;
	logic valid_s2;
	logic s2_free;
	logic advance;
	logic in_accept;

	assign s2_free   = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			raw_s1 <= raw_level;
		end
	end

	// ------------------------------------------------------------------
	// Debounce and classification state. The previous debounced level is
	// always equal to the stored debounced level between ticks, so an edge
	// is detected by comparing the new level with the stored one.
	// ------------------------------------------------------------------
	logic   raw_seen_q;
	logic   settling_q;
	timer_t settle_cnt_q;
	logic   stable_q;
	logic   long_armed_q;
	timer_t hold_cnt_q;

	logic    raw_seen_d;
	logic    settling_d;
	timer_t  settle_cnt_d;
	logic    stable_d;
	logic    long_armed_d;
	timer_t  hold_cnt_d;
	timer_t  hold_inc;
	result_t res_d;

	always_comb begin
		// The hold timer advances every tick, unless a press restarts it, and saturates at all ones.
		hold_inc     = (hold_cnt_q == '1) ? hold_cnt_q : hold_cnt_q + 1'b1;
		hold_cnt_d   = hold_inc;
		raw_seen_d   = raw_seen_q;
		settling_d   = settling_q;
		settle_cnt_d = settle_cnt_q;
		stable_d     = stable_q;
		long_armed_d = long_armed_q;
		res_d        = '0;

		// A change of the raw level restarts the settle counter.
		if (raw_s1 != raw_seen_q) begin
			raw_seen_d   = raw_s1;
			settling_d   = 1'b1;
			settle_cnt_d = '0;
		end else if (settling_q) begin
			settle_cnt_d = (settle_cnt_q == '1) ? settle_cnt_q : settle_cnt_q + 1'b1;
		end

		// With a zero debounce time the new level is taken at once.
		if (settling_d && (CMP_W'(settle_cnt_d) >= CMP_W'(debounce_ms_q))) begin
			stable_d   = raw_seen_d;
			settling_d = 1'b0;
		end

		if (stable_d != stable_q) begin
			if (stable_d == LEVEL_PRESSED) begin
				res_d.press  = 1'b1;
				long_armed_d = 1'b1;
				hold_cnt_d   = '0;
			end else begin
				// A saturated hold timer still compares against the limit.
				res_d.short_ev   = (CMP_W'(hold_inc) <= CMP_W'(short_max_ms_q));
				res_d.release_ev = 1'b1;
				long_armed_d     = 1'b0;
			end
		end

		// Fires once per press; a zero long time fires with the press itself.
		if (long_armed_d && (CMP_W'(hold_cnt_d) >= CMP_W'(long_ms_q))) begin
			res_d.long_ev = 1'b1;
			long_armed_d  = 1'b0;
		end

		res_d.stable = stable_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q   <= LEVEL_RELEASED;
			settling_q   <= 1'b0;
			settle_cnt_q <= '0;
			stable_q     <= LEVEL_RELEASED;
			long_armed_q <= 1'b0;
			hold_cnt_q   <= '0;
		end else if (advance) begin
			raw_seen_q   <= raw_seen_d;
			settling_q   <= settling_d;
			settle_cnt_q <= settle_cnt_d;
			stable_q     <= stable_d;
			long_armed_q <= long_armed_d;
			hold_cnt_q   <= hold_cnt_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign stable_out    = res_s2.stable;
	assign press_event   = res_s2.press;
	assign release_event = res_s2.release_ev;
	assign short_event   = res_s2.short_ev;
	assign long_event    = res_s2.long_ev;

endmodule

### src/bdpc_checker.sv
// ----------------------------------------------------------------------------
// bdpc_checker: port-level checks for the button debounce press classifier
// Watches the result channel and flags inconsistent event words.
// ----------------------------------------------------------------------------
module bdpc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic                stable_out,
	input logic                press_event,
	input logic                release_event,
	input logic                short_event,
	input logic                long_event
);
	import bdpc_pkg::*;

	// A word cannot report both edges of the debounced level.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(press_event && release_event))
		else $error("press and release in the same word");

	// A short press is only ever reported together with its release.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && short_event) |-> release_event)
		else $error("short press without release");

	// Edge events agree with the level shown in the same word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (press_event || release_event)) |->
		(stable_out == (release_event ? LEVEL_RELEASED : LEVEL_PRESSED)))
		else $error("edge event disagrees with debounced level");

	// A stalled result word stays on the port.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result word dropped while stalled");

	// A long press comes at most once per word and never with a release.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && long_event) |-> !release_event)
		else $error("long press together with release");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);
